// File: src/sitda_pkg.sv
package sitda_pkg;

    // Sequencer step addresses
    localparam logic [1:0] STEP_IDLE  = 2'd0;
    localparam logic [1:0] STEP_CHECK = 2'd1;
    localparam logic [1:0] STEP_DIGIT = 2'd2;
    localparam logic [1:0] STEP_SIGN  = 2'd3;

    // Emit selects
    localparam logic [1:0] EM_NONE  = 2'd0;
    localparam logic [1:0] EM_SIGN  = 2'd1;
    localparam logic [1:0] EM_DIGIT = 2'd2;

    // Branch conditions
    localparam logic [1:0] CD_ALWAYS     = 2'd0;
    localparam logic [1:0] CD_IN_ACCEPT  = 2'd1;
    localparam logic [1:0] CD_NEG        = 2'd2;
    localparam logic [1:0] CD_LAST_DIGIT = 2'd3;

    // Result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_PARAM = 2'd1;
    localparam logic [1:0] ST_NO_SPACE  = 2'd2;

    // ASCII codes
    localparam logic [6:0] CH_MINUS = 7'h2D;
    localparam logic [6:0] CH_ZERO  = 7'h30;
    localparam logic [6:0] CH_NINE  = 7'h39;

    localparam logic [3:0] LAST_POS = 4'd9;

    // One control word of the microprogram
    typedef struct packed {
        logic       load;
        logic       check;
        logic [1:0] emit;
        logic [1:0] cond;
        logic [1:0] tgt_true;
        logic [1:0] tgt_false;
    } ctl_t;

    // Datapath flags seen by the sequencer
    typedef struct packed {
        logic go;
        logic neg;
        logic err;
        logic last_digit;
    } dp_status_t;

    // Power of ten for a digit position, most significant first
    function automatic logic [31:0] pow10(input logic [3:0] pos);
        logic [31:0] r;
        case (pos)
            4'd0:    r = 32'd1000000000;
            4'd1:    r = 32'd100000000;
            4'd2:    r = 32'd10000000;
            4'd3:    r = 32'd1000000;
            4'd4:    r = 32'd100000;
            4'd5:    r = 32'd10000;
            4'd6:    r = 32'd1000;
            4'd7:    r = 32'd100;
            4'd8:    r = 32'd10;
            4'd9:    r = 32'd1;
            default: r = 32'd1;
        endcase
        return r;
    endfunction

endpackage

// File: src/sitda_if.sv
interface sitda_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] value;
    logic [11:0] dest_size;

    modport source (output valid, output value, output dest_size, input ready);
    modport sink (input valid, input value, input dest_size, output ready);
endinterface

interface sitda_out_if;
    logic       valid;
    logic       ready;
    logic [6:0] character;
    logic       last;
    logic [1:0] status;
    logic [3:0] length;

    modport source (output valid, output character, output last, output status,
                    output length, input ready);
    modport sink (input valid, input character, input last, input status,
                  input length, output ready);
endinterface

// File: src/sitda_rom.sv
module sitda_rom (
    input  logic [1:0]     step,
    output sitda_pkg::ctl_t ctl
);
    import sitda_pkg::*;

    // Microprogram: wait, check room, optional sign, one digit per step
    always_comb
    begin
        case (step)
            STEP_IDLE:
                ctl = '{load: 1'b1, check: 1'b0, emit: EM_NONE, cond: CD_IN_ACCEPT,
                        tgt_true: STEP_CHECK, tgt_false: STEP_IDLE};
            STEP_CHECK:
                ctl = '{load: 1'b0, check: 1'b1, emit: EM_NONE, cond: CD_NEG,
                        tgt_true: STEP_SIGN, tgt_false: STEP_DIGIT};
            STEP_DIGIT:
                ctl = '{load: 1'b0, check: 1'b0, emit: EM_DIGIT, cond: CD_LAST_DIGIT,
                        tgt_true: STEP_IDLE, tgt_false: STEP_DIGIT};
            STEP_SIGN:
                ctl = '{load: 1'b0, check: 1'b0, emit: EM_SIGN, cond: CD_ALWAYS,
                        tgt_true: STEP_DIGIT, tgt_false: STEP_DIGIT};
            default:
                ctl = '{load: 1'b1, check: 1'b0, emit: EM_NONE, cond: CD_IN_ACCEPT,
                        tgt_true: STEP_CHECK, tgt_false: STEP_IDLE};
        endcase
    end

endmodule

// File: src/sitda_datapath.sv
module sitda_datapath (
    input  logic                   clk,
    input  logic                   rst_n,
    input  sitda_pkg::ctl_t        ctl,
    input  logic                   in_fire,
    input  logic [31:0]            value,
    input  logic [11:0]            dest_size,
    input  logic                   out_ready,
    output sitda_pkg::dp_status_t  st,
    output logic                   out_valid,
    output logic [6:0]             character,
    output logic                   last,
    output logic [1:0]             status,
    output logic [3:0]             length
);
    import sitda_pkg::*;

    logic [31:0] mag_reg, mag_next;
    logic        neg_reg, neg_next;
    logic [11:0] size_reg, size_next;
    logic [3:0]  pos_reg, pos_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic        out_valid_reg, out_valid_next;
    logic [6:0]  char_reg, char_next;
    logic        last_reg, last_next;
    logic [1:0]  status_reg, status_next;
    logic [3:0]  length_reg, length_next;

    logic [31:0] in_mag;
    logic [3:0]  start_pos;
    logic [3:0]  total;
    logic        err_bad;
    logic        err_space;
    logic        err;
    logic        emit_req;
    logic        slot_free;
    logic        go;
    logic        last_digit;
    logic [33:0] cand [10];
    logic [3:0]  digit;
    logic [33:0] sub_val;

    // Magnitude and leading-zero skip of the incoming word
    always_comb
    begin
        in_mag = value[31] ? (32'd0 - value) : value;
        start_pos = 4'd0;
        for (int i = 0; i < 9; i++)
        begin
            if (in_mag < pow10(4'(i)))
                start_pos = start_pos + 4'd1;
        end
    end

    // Room check
    always_comb
    begin
        total = {3'b000, neg_reg} + (4'd10 - pos_reg);
        err_bad = (size_reg == 12'd0);
        err_space = ({8'd0, total} >= size_reg);
        err = err_bad || err_space;
    end

    // Digit: compare against all multiples of the current power at once
    always_comb
    begin
        cand[0] = 34'd0;
        for (int d = 1; d < 10; d++)
            cand[d] = {2'b00, pow10(pos_reg)} * 34'(d);
        digit = 4'd0;
        for (int d = 1; d < 10; d++)
        begin
            if ({2'b00, mag_reg} >= cand[d])
                digit = digit + 4'd1;
        end
        sub_val = cand[digit];
    end

    // Handshake with the output register
    always_comb
    begin
        last_digit = (pos_reg == LAST_POS);
        emit_req = (ctl.emit != EM_NONE) || (ctl.check && err);
        slot_free = !out_valid_reg || out_ready;
        go = !emit_req || slot_free;
    end

    assign st = '{go: go, neg: neg_reg, err: err, last_digit: last_digit};

    // Next state of the working registers and the output register
    always_comb
    begin
        mag_next = mag_reg;
        neg_next = neg_reg;
        size_next = size_reg;
        pos_next = pos_reg;
        cnt_next = cnt_reg;
        out_valid_next = out_valid_reg && !out_ready;
        char_next = char_reg;
        last_next = last_reg;
        status_next = status_reg;
        length_next = length_reg;

        if (in_fire)
        begin
            mag_next = in_mag;
            neg_next = value[31];
            size_next = dest_size;
            pos_next = start_pos;
            cnt_next = 4'd0;
        end

        if (go)
        begin
            if (ctl.check && err)
            begin
                out_valid_next = 1'b1;
                char_next = 7'd0;
                last_next = 1'b1;
                status_next = err_bad ? ST_BAD_PARAM : ST_NO_SPACE;
                length_next = 4'd0;
            end
            else if (ctl.emit == EM_SIGN)
            begin
                out_valid_next = 1'b1;
                char_next = CH_MINUS;
                last_next = 1'b0;
                status_next = ST_OK;
                length_next = 4'd0;
                cnt_next = cnt_reg + 4'd1;
            end
            else if (ctl.emit == EM_DIGIT)
            begin
                out_valid_next = 1'b1;
                char_next = CH_ZERO + {3'b000, digit};
                last_next = last_digit;
                status_next = ST_OK;
                length_next = last_digit ? (cnt_reg + 4'd1) : 4'd0;
                cnt_next = cnt_reg + 4'd1;
                mag_next = mag_reg - sub_val[31:0];
                pos_next = pos_reg + 4'd1;
            end
        end
    end

    // Control register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        mag_reg <= mag_next;
        neg_reg <= neg_next;
        size_reg <= size_next;
        pos_reg <= pos_next;
        cnt_reg <= cnt_next;
        char_reg <= char_next;
        last_reg <= last_next;
        status_reg <= status_next;
        length_reg <= length_next;
    end

    assign out_valid = out_valid_reg;
    assign character = char_reg;
    assign last = last_reg;
    assign status = status_reg;
    assign length = length_reg;

`ifndef NO_ASSERTIONS
    // An error word is a lone, empty, final word
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && status_reg != ST_OK |->
            last_reg && length_reg == 4'd0 && char_reg == 7'd0)
        else $error("error word with payload");

    // A good word is a minus sign or a decimal digit
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && status_reg == ST_OK |->
            char_reg == CH_MINUS || (char_reg >= CH_ZERO && char_reg <= CH_NINE))
        else $error("bad character");

    // Digit emits never run past the ones place
    assert property (@(posedge clk) disable iff (!rst_n)
        ctl.emit == EM_DIGIT |-> pos_reg <= LAST_POS)
        else $error("digit position overrun");

    // The remainder stays below ten times the current power
    assert property (@(posedge clk) disable iff (!rst_n)
        ctl.emit == EM_DIGIT && pos_reg != 4'd0 |->
            {2'b00, mag_reg} < ({2'b00, pow10(pos_reg)} * 34'd10))
        else $error("remainder too large for digit");
`endif

endmodule

// File: src/signed_int_to_decimal_ascii_top.sv
// Flow: the input word is registered into the working registers, then the check
// step tests for room and writes an error word if there is none, then one word per cycle unless the output stalls.
// A new input word is taken only in the idle step, after the last character or
// the error word of the previous one; the sequencer emits one character per step.
// Reset: rst_n is asynchronous, active low; it returns the sequencer to idle
// and empties the output register.
module signed_int_to_decimal_ascii_top (
    input logic         clk,
    input logic         rst_n,
    sitda_in_if.sink    in_ch,
    sitda_out_if.source out_ch
);
    import sitda_pkg::*;

    logic [1:0]  step_reg, step_next;
    ctl_t        ctl;
    dp_status_t  st;
    logic        in_fire;
    logic        cond_true;

    sitda_rom u_rom (
        .step (step_reg),
        .ctl  (ctl)
    );

    assign in_ch.ready = ctl.load;
    assign in_fire = in_ch.valid && ctl.load;

    sitda_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .in_fire     (in_fire),
        .value       (in_ch.value),
        .dest_size   (in_ch.dest_size),
        .out_ready   (out_ch.ready),
        .st          (st),
        .out_valid   (out_ch.valid),
        .character   (out_ch.character),
        .last        (out_ch.last),
        .status      (out_ch.status),
        .length      (out_ch.length)
    );

    // Evaluate the branch condition of the current control word
    always_comb
    begin
        case (ctl.cond)
            CD_ALWAYS:     cond_true = 1'b1;
            CD_IN_ACCEPT:  cond_true = in_fire;
            CD_NEG:        cond_true = st.neg;
            CD_LAST_DIGIT: cond_true = st.last_digit;
            default:       cond_true = 1'b1;
        endcase
    end

    // Advance the step counter; hold while an emit finds the output register full and not taken
    always_comb
    begin
        step_next = step_reg;
        if (st.go)
        begin
            if (ctl.check && st.err)
                step_next = STEP_IDLE;
            else
                step_next = cond_true ? ctl.tgt_true : ctl.tgt_false;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            step_reg <= STEP_IDLE;
        else
            step_reg <= step_next;
    end

`ifndef NO_ASSERTIONS
    // Input is taken only in the idle step
    assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |-> step_reg == STEP_IDLE)
        else $error("input taken while busy");

    // A taken input always leads to the room check
    assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> step_reg == STEP_CHECK)
        else $error("check step skipped");

    // The sign step is reached only for negative values
    assert property (@(posedge clk) disable iff (!rst_n)
        step_reg == STEP_SIGN |-> st.neg)
        else $error("sign for non-negative value");
`endif

endmodule
